>>> rtl/core/mcds_pkg.sv
// ----------------------------------------------------------------------------
// mcds_pkg
// Types, register indexes and timing constants for the motor command dwell
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcds_pkg;

  typedef enum logic [1:0] {
    CMD_STOP  = 2'd0,
    CMD_BACK  = 2'd1,
    CMD_LEFT  = 2'd2,
    CMD_RIGHT = 2'd3
  } cmd_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_TOL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_GAINS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAINS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAINS = 3'd5;

  localparam logic [15:0] REST_MS     = 16'd1500;
  localparam logic [15:0] TURN_MAX_MS = 16'd100;
  localparam logic [15:0] BACK_MAX_MS = 16'd800;

  // Heading of a target straight behind, tenths of a degree
  localparam logic signed [13:0] HEAD_BEHIND = 14'sd1800;

  localparam logic [5:0] MOTOR_CENTER = 6'd32;
  localparam logic [5:0] MOTOR_REV    = 6'd31;
  localparam logic [7:0] RIGHT_TAG    = 8'h80;
  localparam logic [7:0] LEFT_TAG     = 8'h40;

  localparam logic [15:0] DIST_TOL_RST  = 16'd50;
  localparam logic [10:0] HEAD_TOL_RST  = 11'd100;
  localparam logic [9:0]  GAINS_RST     = 10'd462;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage : mcds_pkg

`default_nettype wire

>>> rtl/core/motor_command_dwell_sequencer.sv
// A result is registered in the cycle after its input transfer.
// Throughput: one tick per cycle while the output is not stalled; the decision
// and the timer update are one combinational pass from the input port into the result and state registers.
// Reset (synchronous, rst_n low): disabled, registers at defaults, previous
// command stop, all timers zero, no result pending.
// ----------------------------------------------------------------------------
// motor_command_dwell_sequencer
// Picks stop/back/left/right per tick, enforces rest and move time limits,
// and emits the command with the two motor bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motor_command_dwell_sequencer
  import mcds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: distance_mm[15:0], heading_error[27:16], elapsed_ms[43:28], zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [47:0]           in_tdata,
  // in_tuser: no_target[0]
  input  wire logic                  in_tuser,
  // out_tdata: command[1:0], right_motor_byte[9:2], left_motor_byte[17:10], zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        enable_r;
  logic [15:0] dist_tol_r;
  logic [10:0] head_tol_r;
  logic [9:0]  back_gains_r, right_gains_r, left_gains_r;

  cmd_t        prev_cmd_r, prev_cmd_nxt;
  logic [15:0] stop_tmr_r, stop_tmr_nxt;
  logic [15:0] back_tmr_r, back_tmr_nxt;
  logic [15:0] right_tmr_r, right_tmr_nxt;
  logic [15:0] left_tmr_r, left_tmr_nxt;

  logic        out_valid_r;
  logic [23:0] out_data_r, out_data_nxt;

  logic               in_xfer;
  logic [15:0]        dist_mm;
  logic signed [11:0] head;
  logic [15:0]        dt;
  logic signed [13:0] d_fwd, d_rev;
  logic [13:0]        a_fwd, a_rev;
  cmd_t               choice, issued;
  logic [15:0]        sel_tmr, sel_cap;
  logic [9:0]         gains;
  logic [5:0]         vr, vl;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign dist_mm = in_tdata[15:0];
  assign head    = in_tdata[27:16];
  assign dt      = in_tdata[43:28];

  always_comb begin
    d_fwd = 14'(head) - HEAD_BEHIND;
    d_rev = 14'(head) + HEAD_BEHIND;
    a_fwd = d_fwd[13] ? 14'(-d_fwd) : 14'(d_fwd);
    a_rev = d_rev[13] ? 14'(-d_rev) : 14'(d_rev);

    if (in_tuser || dist_mm <= dist_tol_r) begin
      choice = CMD_STOP;
    end else if (a_fwd <= {3'b000, head_tol_r} || a_rev <= {3'b000, head_tol_r}) begin
      choice = CMD_BACK;
    end else if (!head[11]) begin
      choice = CMD_LEFT;
    end else begin
      choice = CMD_RIGHT;
    end
  end

  always_comb begin
    case (choice)
      CMD_BACK:  begin sel_tmr = back_tmr_r;  sel_cap = BACK_MAX_MS; end
      CMD_LEFT:  begin sel_tmr = left_tmr_r;  sel_cap = TURN_MAX_MS; end
      default:   begin sel_tmr = right_tmr_r; sel_cap = TURN_MAX_MS; end
    endcase
  end

  // Dwell rules; the selected move timer is written back by choice
  always_comb begin
    logic        tmr_wr;
    logic [15:0] tmr_val;
    tmr_wr       = 1'b0;
    tmr_val      = '0;
    stop_tmr_nxt = stop_tmr_r;
    issued       = CMD_STOP;
    if (choice == CMD_STOP) begin
      stop_tmr_nxt = (prev_cmd_r != CMD_STOP) ? 16'd0 : sat_add16(stop_tmr_r, dt);
    end else if (prev_cmd_r == CMD_STOP) begin
      if (stop_tmr_r >= REST_MS) begin
        tmr_wr  = 1'b1;
        tmr_val = 16'd0;
        issued  = choice;
      end else begin
        stop_tmr_nxt = sat_add16(stop_tmr_r, dt);
      end
    end else if (prev_cmd_r == choice) begin
      if (sel_tmr <= sel_cap) begin
        tmr_wr  = 1'b1;
        tmr_val = sat_add16(sel_tmr, dt);
        issued  = choice;
      end else begin
        stop_tmr_nxt = 16'd0;
      end
    end else begin
      stop_tmr_nxt = 16'd0;
    end

    back_tmr_nxt  = (tmr_wr && choice == CMD_BACK)  ? tmr_val : back_tmr_r;
    left_tmr_nxt  = (tmr_wr && choice == CMD_LEFT)  ? tmr_val : left_tmr_r;
    right_tmr_nxt = (tmr_wr && choice == CMD_RIGHT) ? tmr_val : right_tmr_r;
    prev_cmd_nxt  = issued;
  end

  always_comb begin
    case (issued)
      CMD_BACK:  gains = back_gains_r;
      CMD_RIGHT: gains = right_gains_r;
      CMD_LEFT:  gains = left_gains_r;
      default:   gains = '0;
    endcase
    case (issued)
      CMD_BACK: begin
        vr = MOTOR_REV - {1'b0, gains[4:0]};
        vl = MOTOR_REV - {1'b0, gains[9:5]};
      end
      CMD_RIGHT: begin
        vr = MOTOR_CENTER + {1'b0, gains[4:0]};
        vl = MOTOR_REV - {1'b0, gains[9:5]};
      end
      CMD_LEFT: begin
        vr = MOTOR_REV - {1'b0, gains[4:0]};
        vl = MOTOR_CENTER + {1'b0, gains[9:5]};
      end
      default: begin
        vr = MOTOR_CENTER;
        vl = MOTOR_CENTER;
      end
    endcase
    out_data_nxt = {6'd0, (LEFT_TAG | {2'b00, vl}), (RIGHT_TAG | {2'b00, vr}), issued};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      dist_tol_r    <= DIST_TOL_RST;
      head_tol_r    <= HEAD_TOL_RST;
      back_gains_r  <= GAINS_RST;
      right_gains_r <= GAINS_RST;
      left_gains_r  <= GAINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:      enable_r      <= cfg_data[0];
        REG_DIST_TOL:    dist_tol_r    <= cfg_data;
        REG_HEAD_TOL:    head_tol_r    <= cfg_data[10:0];
        REG_BACK_GAINS:  back_gains_r  <= cfg_data[9:0];
        REG_RIGHT_GAINS: right_gains_r <= cfg_data[9:0];
        REG_LEFT_GAINS:  left_gains_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cmd_r  <= CMD_STOP;
      stop_tmr_r  <= '0;
      back_tmr_r  <= '0;
      right_tmr_r <= '0;
      left_tmr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      // disabled ticks are consumed without a result or a state change
      if (in_xfer && enable_r) begin
        prev_cmd_r  <= prev_cmd_nxt;
        stop_tmr_r  <= stop_tmr_nxt;
        back_tmr_r  <= back_tmr_nxt;
        right_tmr_r <= right_tmr_nxt;
        left_tmr_r  <= left_tmr_nxt;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && enable_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule : motor_command_dwell_sequencer

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor command dwell sequencer: drives control
// ticks and register writes, predicts each command and motor byte pair from
// its own copy of the dwell state, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mcds_pkg::*;

typedef struct packed {
  logic [15:0] distance_mm;
  logic [11:0] heading_error;
  logic        no_target;
  logic [15:0] elapsed_ms;
} tick_t;

typedef struct packed {
  cmd_t       command;
  logic [7:0] right_byte;
  logic [7:0] left_byte;
} motor_out_t;

class dwell_scoreboard;
  bit         enable;
  bit [15:0]  dist_tol;
  bit [10:0]  head_tol;
  bit [9:0]   back_gains;
  bit [9:0]   right_gains;
  bit [9:0]   left_gains;
  cmd_t       last_cmd;
  bit [15:0]  rest_ms;
  bit [15:0]  move_ms [4];
  motor_out_t expected_q [$];
  int         errors;

  function new();
    enable      = 1'b0;
    dist_tol    = DIST_TOL_RST;
    head_tol    = HEAD_TOL_RST;
    back_gains  = GAINS_RST;
    right_gains = GAINS_RST;
    left_gains  = GAINS_RST;
    last_cmd    = CMD_STOP;
    rest_ms     = '0;
    foreach (move_ms[i]) move_ms[i] = '0;
    errors      = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit [15:0] add_clamped(bit [15:0] a, bit [15:0] b);
    if (int'(a) + int'(b) > 65535) return 16'hFFFF;
    return a + b;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ENABLE:      enable      = d[0];
      REG_DIST_TOL:    dist_tol    = d;
      REG_HEAD_TOL:    head_tol    = d[10:0];
      REG_BACK_GAINS:  back_gains  = d[9:0];
      REG_RIGHT_GAINS: right_gains = d[9:0];
      REG_LEFT_GAINS:  left_gains  = d[9:0];
      default: ;
    endcase
  endfunction

  function void note_tick(tick_t t);
    int         h;
    int         tol;
    int         off_fwd;
    int         off_rev;
    cmd_t       want;
    cmd_t       issued;
    bit [15:0]  cap;
    bit [5:0]   vr;
    bit [5:0]   vl;
    motor_out_t r;
    if (!enable) return;
    h   = int'($signed(t.heading_error));
    tol = int'(head_tol);
    off_fwd = h - HEAD_BEHIND;
    if (off_fwd < 0) off_fwd = -off_fwd;
    off_rev = h + HEAD_BEHIND;
    if (off_rev < 0) off_rev = -off_rev;

    if (t.no_target || t.distance_mm <= dist_tol) want = CMD_STOP;
    else if (off_fwd <= tol || off_rev <= tol) want = CMD_BACK;
    else if (h >= 0) want = CMD_LEFT;
    else want = CMD_RIGHT;

    issued = CMD_STOP;
    if (want == CMD_STOP) begin
      rest_ms = (last_cmd == CMD_STOP) ? add_clamped(rest_ms, t.elapsed_ms) : 16'd0;
    end else if (last_cmd == CMD_STOP) begin
      // a move may only start once the rest has run its full length
      if (rest_ms >= REST_MS) begin
        move_ms[want] = '0;
        issued = want;
      end else begin
        rest_ms = add_clamped(rest_ms, t.elapsed_ms);
      end
    end else if (last_cmd == want) begin
      cap = (want == CMD_BACK) ? BACK_MAX_MS : TURN_MAX_MS;
      if (move_ms[want] <= cap) begin
        move_ms[want] = add_clamped(move_ms[want], t.elapsed_ms);
        issued = want;
      end else begin
        rest_ms = '0;
      end
    end else begin
      rest_ms = '0;
    end

    vr = MOTOR_CENTER;
    vl = MOTOR_CENTER;
    case (issued)
      CMD_BACK: begin
        vr = MOTOR_REV - back_gains[4:0];
        vl = MOTOR_REV - back_gains[9:5];
      end
      CMD_RIGHT: begin
        vr = MOTOR_CENTER + right_gains[4:0];
        vl = MOTOR_REV - right_gains[9:5];
      end
      CMD_LEFT: begin
        vr = MOTOR_REV - left_gains[4:0];
        vl = MOTOR_CENTER + left_gains[9:5];
      end
      default: ;
    endcase
    last_cmd     = issued;
    r.command    = issued;
    r.right_byte = RIGHT_TAG | {2'b00, vr};
    r.left_byte  = LEFT_TAG | {2'b00, vl};
    expected_q.push_back(r);
  endfunction

  task report(string field, logic [23:0] got, logic [23:0] want);
    errors++;
    if (errors <= 100)
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  task check_result(logic [23:0] w);
    motor_out_t e;
    if (expected_q.size() == 0) begin
      report("unexpected result", w, 24'd0);
      return;
    end
    e = expected_q.pop_front();
    if (w[1:0] !== e.command) report("command", w[1:0], e.command);
    if (w[9:2] !== e.right_byte) report("right_motor_byte", w[9:2], e.right_byte);
    if (w[17:10] !== e.left_byte) report("left_motor_byte", w[17:10], e.left_byte);
  endtask
endclass

module tb;
  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bit              gaps_on     = 1'b1;
  int              cycle_count = 0;
  dwell_scoreboard sb          = new();

  motor_command_dwell_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // transfer monitors; values read here are the ones from before the edge
  always @(posedge clk) begin : watch
    tick_t seen;
    if (rst_n && in_tvalid && in_tready) begin
      seen.distance_mm   = in_tdata[15:0];
      seen.heading_error = in_tdata[27:16];
      seen.elapsed_ms    = in_tdata[43:28];
      seen.no_target     = in_tuser;
      sb.note_tick(seen);
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  initial begin : sink_pace
    forever begin
      @(posedge clk);
      if (gaps_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic tick_t tk(input int dist_val, input int head, input bit none,
                               input int dt);
    tick_t t;
    t.distance_mm   = dist_val[15:0];
    t.heading_error = head[11:0];
    t.no_target     = none;
    t.elapsed_ms    = dt[15:0];
    return t;
  endfunction

  function automatic tick_t rest_tick();
    tick_t t;
    t.no_target     = 1'($urandom_range(0, 1));
    t.distance_mm   = 16'($urandom_range(0, sb.dist_tol));
    t.heading_error = 12'($urandom);
    t.elapsed_ms    = 16'($urandom_range(100, 900));
    return t;
  endfunction

  function automatic tick_t move_tick(input cmd_t kind);
    tick_t t;
    int    off;
    int    h;
    t.no_target   = 1'b0;
    t.distance_mm = (sb.dist_tol == 16'hFFFF) ? 16'hFFFF
                  : 16'($urandom_range(int'(sb.dist_tol) + 1, 65535));
    case (kind)
      CMD_BACK: begin
        off = $urandom_range(0, (sb.head_tol < 247) ? sb.head_tol : 247);
        h = $urandom_range(0, 1) ? 1800 - off : 1800 + off;
        if ($urandom_range(0, 1)) h = -h;
      end
      CMD_LEFT: h = $urandom_range(0, 1800);
      default:  h = -int'($urandom_range(1, 1800));
    endcase
    t.heading_error = 12'(h);
    t.elapsed_ms = 16'((kind == CMD_BACK) ? $urandom_range(0, 250) : $urandom_range(0, 40));
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.no_target     = 1'($urandom_range(0, 1));
    t.distance_mm   = 16'($urandom);
    t.heading_error = 12'($urandom);
    t.elapsed_ms    = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, t.elapsed_ms, t.heading_error, t.distance_mm};
    in_tuser  <= t.no_target;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // caller drops cfg_valid after the last write of a batch
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly rest-then-move sequences so the dwell timers get exercised
  task automatic run_ticks(input int count, input bit pause_midway);
    int   sent;
    int   run_len;
    cmd_t kind;
    sent = 0;
    while (sent < count) begin
      if (pause_midway && sent >= count / 2) begin
        settle();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          send_tick(rest_tick());
          sent++;
        end
        kind = cmd_t'($urandom_range(1, 3));
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          if ($urandom_range(0, 15) == 0) kind = cmd_t'($urandom_range(1, 3));
          send_tick(move_tick(kind));
          sent++;
        end
      end else begin
        send_tick(noise_tick());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int phase_len [6];
    phase_len = '{300, 100, 300, 40, 300, 400};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // block comes up disabled: these must produce nothing
    send_tick(tk(1000, 0, 0, 2000));
    send_tick(tk(0, -1, 1, 5));
    settle();
    write_register(REG_ENABLE, 16'd1);
    cfg_valid <= 1'b0;

    send_tick(tk(1000, 0, 1, 65535));   // no target, rest saturates
    send_tick(tk(50, 0, 0, 65535));     // distance at tolerance
    send_tick(tk(65535, 1800, 0, 10));  // back starts after rest
    send_tick(tk(51, -1800, 0, 900));
    send_tick(tk(51, 1700, 0, 5));      // back past its cap
    send_tick(tk(2000, 0, 0, 2000));    // left refused, rest too short
    send_tick(tk(2000, 1, 0, 30));
    send_tick(tk(2000, 1699, 0, 80));
    send_tick(tk(2000, 0, 0, 30));
    send_tick(tk(2000, 5, 0, 1));       // turn past its cap
    send_tick(tk(0, 0, 0, 1500));
    send_tick(tk(2000, -1, 0, 7));
    send_tick(tk(2000, -1699, 0, 7));
    send_tick(tk(2000, 1000, 0, 7));    // move right after a different move
    send_tick(tk(3000, 2047, 0, 0));    // heading beyond range
    send_tick(tk(3000, -2048, 0, 2000));
    send_tick(tk(3000, -1701, 0, 0));
    send_tick(tk(3000, -1800, 0, 800));
    send_tick(tk(3000, 1800, 0, 65535));
    send_tick(tk(3000, 1800, 0, 0));

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          write_register(REG_DIST_TOL, 16'd0);
          write_register(REG_HEAD_TOL, 16'd0);
          write_register(REG_BACK_GAINS, 16'd0);
          write_register(REG_RIGHT_GAINS, 16'd0);
          write_register(REG_LEFT_GAINS, 16'd0);
        end
        1: begin
          write_register(REG_DIST_TOL, 16'hFFFF);
          write_register(REG_HEAD_TOL, 16'd100);
        end
        2: begin
          write_register(REG_DIST_TOL, 16'($urandom_range(0, 3000)));
          write_register(REG_HEAD_TOL, 16'd1800);
          write_register(REG_BACK_GAINS, 16'h03FF);
          write_register(REG_RIGHT_GAINS, 16'h03FF);
          write_register(REG_LEFT_GAINS, 16'h03FF);
        end
        3: write_register(REG_ENABLE, 16'hFFFE);
        4: begin
          // upper bits beyond each register's width are dropped
          write_register(REG_ENABLE, 16'hFFFF);
          write_register(REG_HEAD_TOL, 16'hFFFF);
          write_register(REG_DIST_TOL, 16'd200);
          write_register(REG_BACK_GAINS, 16'($urandom));
          write_register(REG_RIGHT_GAINS, 16'($urandom));
          write_register(REG_LEFT_GAINS, 16'($urandom));
        end
        default: begin
          write_register(REG_DIST_TOL, 16'($urandom_range(0, 5000)));
          write_register(REG_HEAD_TOL, 16'($urandom_range(0, 400)));
          write_register(REG_BACK_GAINS, 16'($urandom));
          write_register(REG_RIGHT_GAINS, 16'($urandom));
          write_register(REG_LEFT_GAINS, 16'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;
      gaps_on = (p != 5);
      run_ticks(phase_len[p], p == 2);
    end

    settle();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
